### hw/rtl/lcd_scanline_mode_timer_defines.svh
// ----------------------------------------------------------------------------
// lcd_scanline_mode_timer_defines.svh
// Assertion macros for the scanline mode timer; bodies are empty in synthesis
// ----------------------------------------------------------------------------
`ifndef LCD_SCANLINE_MODE_TIMER_DEFINES_SVH
`define LCD_SCANLINE_MODE_TIMER_DEFINES_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge out of reset
`define LSMT_ASSERT(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("lcd_scanline_mode_timer: assertion failed");

// antecedent in this cycle implies consequent in the next cycle
`define LSMT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcd_scanline_mode_timer: assertion failed");

`else

`define LSMT_ASSERT(label, expr)
`define LSMT_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### hw/rtl/lsmt_pkg.sv
// ----------------------------------------------------------------------------
// lsmt_pkg
// Types and fixed constants of the scanline mode timer
// ----------------------------------------------------------------------------
package lsmt_pkg;

    // display mode as reported in the status word
    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_DRAW   = 2'd3
    } mode_t;

    // configuration register indexes
    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t CFG_DISPLAY_ENABLE     = 2'd0;
    localparam cfg_index_t CFG_LINE_COMPARE       = 2'd1;
    localparam cfg_index_t CFG_STATUS_IRQ_ENABLES = 2'd2;

    // status request enable bit positions
    localparam int unsigned IRQ_EN_HBLANK = 0;
    localparam int unsigned IRQ_EN_VBLANK = 1;
    localparam int unsigned IRQ_EN_OAM    = 2;
    localparam int unsigned IRQ_EN_LYC    = 3;

    // last line that is drawn; lines after it are vertical blank
    localparam logic [7:0] LAST_VISIBLE_LINE = 8'd143;

endpackage

### hw/rtl/lcd_scanline_mode_timer.sv
// ----------------------------------------------------------------------------
// lcd_scanline_mode_timer
// Dot/line counter and display mode sequencer of an LCD controller
// ----------------------------------------------------------------------------
// Each input transfer carries the number of dot clocks elapsed since the last
// one; each produces exactly one result transfer with the line counter, the
// display mode, the coincidence flag and three one-shot pulses (vblank
// request, gated status request, line-render strobe). One item is taken per
// clock cycle while the result is not stalled: the item is held in an input
// register, and the timer state and the result register are then updated
// together from it by one add and compare-subtract on the dot position plus
// the mode decision. A stalled result holds the input register, which frees
// again in the cycle the result is taken. Configuration writes are always
// accepted and take effect for items that follow.
`include "lcd_scanline_mode_timer_defines.svh"

module lcd_scanline_mode_timer #(
    parameter int unsigned DOTS_PER_LINE   = 456,
    parameter int unsigned LINES_PER_FRAME = 154,
    parameter int unsigned OAM_SCAN_DOTS   = 80,
    parameter int unsigned DRAW_DOTS       = 172
) (
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  lsmt_pkg::cfg_index_t  cfg_index,
    input  logic [7:0]            cfg_data,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            elapsed_dots,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            current_line,
    output logic [1:0]            display_mode,
    output logic                  coincidence_flag,
    output logic                  vblank_request,
    output logic                  status_request,
    output logic                  render_line_strobe
);

    import lsmt_pkg::*;

    localparam logic [9:0] LINE_DOTS  = 10'(DOTS_PER_LINE);
    localparam logic [8:0] LINE_COUNT = 9'(LINES_PER_FRAME);
    localparam logic [9:0] OAM_DOTS   = 10'(OAM_SCAN_DOTS);
    localparam logic [7:0] DRAW_LEN   = 8'(DRAW_DOTS);

    // configuration registers
    logic       display_enable_reg;
    logic [7:0] line_compare_reg;
    logic [3:0] irq_enables_reg;

    // handshake and input register
    logic       in_valid_reg;
    logic [7:0] elapsed_reg;
    logic       out_valid_reg;
    logic       advance;

    // timer state
    logic [8:0] dot_reg;
    logic [8:0] dot_next;
    logic [7:0] line_reg;
    logic [7:0] line_next;
    mode_t      mode_reg;
    mode_t      mode_next;
    logic       coin_reg;
    logic       coin_next;
    logic [7:0] draw_len_reg;
    logic [7:0] draw_len_next;

    // result pulses
    logic       vblank_req_reg;
    logic       vblank_req_next;
    logic       status_req_reg;
    logic       status_req_next;
    logic       strobe_reg;
    logic       strobe_next;

    // step datapath
    logic [9:0] dot_sum;
    logic       line_wrap;
    logic [8:0] dot_step;
    logic [8:0] line_inc;
    logic [7:0] line_step;
    logic [7:0] draw_len_base;
    logic       visible;
    logic       coin_hit;

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            display_enable_reg <= 1'b0;
            line_compare_reg   <= 8'd0;
            irq_enables_reg    <= 4'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_DISPLAY_ENABLE:     display_enable_reg <= cfg_data[0];
                CFG_LINE_COMPARE:       line_compare_reg   <= cfg_data;
                CFG_STATUS_IRQ_ENABLES: irq_enables_reg    <= cfg_data[3:0];
                default:                ;
            endcase
        end
    end

    // handshake: an item moves on when the result slot is free or being taken
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // input payload register
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            elapsed_reg <= elapsed_dots;
        end
    end

    // dot position with a single wrap at the line length
    assign dot_sum   = {1'b0, dot_reg} + {2'b00, elapsed_reg};
    assign line_wrap = dot_sum >= LINE_DOTS;
    assign dot_step  = line_wrap ? 9'(dot_sum - LINE_DOTS) : dot_sum[8:0];

    // line counter and coincidence on a line change
    assign line_inc      = {1'b0, line_reg} + 9'd1;
    assign line_step     = !line_wrap ? line_reg :
                           (line_inc == LINE_COUNT) ? 8'd0 : line_inc[7:0];
    assign draw_len_base = line_wrap ? 8'd0 : draw_len_reg;
    assign coin_hit      = line_step == line_compare_reg;
    assign visible       = line_step <= LAST_VISIBLE_LINE;

    // next state: at most one mode change per step
    always_comb
    begin
        dot_next      = dot_step;
        line_next     = line_step;
        coin_next     = line_wrap ? coin_hit : coin_reg;
        draw_len_next = draw_len_base;
        mode_next     = mode_reg;
        if (!display_enable_reg)
        begin
            dot_next      = 9'd0;
            line_next     = 8'd0;
            coin_next     = coin_reg;
            draw_len_next = draw_len_reg;
            mode_next     = MODE_HBLANK;
        end
        else if (!visible)
        begin
            mode_next = MODE_VBLANK;
        end
        else if ({1'b0, dot_step} < OAM_DOTS && mode_reg != MODE_OAM)
        begin
            mode_next = MODE_OAM;
        end
        else if ({1'b0, dot_step} >= OAM_DOTS && mode_reg == MODE_OAM)
        begin
            mode_next     = MODE_DRAW;
            draw_len_next = DRAW_LEN;
        end
        else if ({1'b0, dot_step} >= OAM_DOTS + {2'b00, draw_len_base} &&
                 mode_reg == MODE_DRAW)
        begin
            mode_next = MODE_HBLANK;
        end
    end

    // outputs: pulses from the mode transition and line change of this step
    always_comb
    begin
        vblank_req_next = 1'b0;
        status_req_next = 1'b0;
        strobe_next     = 1'b0;
        if (display_enable_reg)
        begin
            vblank_req_next = mode_reg != MODE_VBLANK && mode_next == MODE_VBLANK;
            strobe_next     = mode_reg == MODE_DRAW && mode_next == MODE_HBLANK;
            status_req_next =
                (line_wrap && coin_hit && irq_enables_reg[IRQ_EN_LYC]) ||
                (vblank_req_next && irq_enables_reg[IRQ_EN_VBLANK]) ||
                (strobe_next && irq_enables_reg[IRQ_EN_HBLANK]) ||
                (mode_reg != MODE_OAM && mode_next == MODE_OAM &&
                 irq_enables_reg[IRQ_EN_OAM]);
        end
    end

    // timer state, updated once per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg      <= 9'd0;
            line_reg     <= 8'd0;
            mode_reg     <= MODE_HBLANK;
            coin_reg     <= 1'b0;
            draw_len_reg <= 8'd0;
        end
        else if (advance)
        begin
            dot_reg      <= dot_next;
            line_reg     <= line_next;
            mode_reg     <= mode_next;
            coin_reg     <= coin_next;
            draw_len_reg <= draw_len_next;
        end
    end

    // result pulses
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vblank_req_reg <= 1'b0;
            status_req_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else if (advance)
        begin
            vblank_req_reg <= vblank_req_next;
            status_req_reg <= status_req_next;
            strobe_reg     <= strobe_next;
        end
    end

    // result fields reflect the state left by the last item
    assign current_line       = line_reg;
    assign display_mode       = mode_reg;
    assign coincidence_flag   = coin_reg;
    assign vblank_request     = vblank_req_reg;
    assign status_request     = status_req_reg;
    assign render_line_strobe = strobe_reg;

    // checks
    `LSMT_ASSERT(a_dot_in_line, {1'b0, dot_reg} < LINE_DOTS)
    `LSMT_ASSERT(a_line_in_frame, {1'b0, line_reg} < LINE_COUNT)
    `LSMT_ASSERT(a_vblank_mode, !vblank_req_reg || (mode_reg == MODE_VBLANK && line_reg > LAST_VISIBLE_LINE))
    `LSMT_ASSERT(a_strobe_hblank, !strobe_reg || mode_reg == MODE_HBLANK)
    `LSMT_ASSERT_NEXT(a_disabled_home, advance && !display_enable_reg, line_reg == 8'd0 && dot_reg == 9'd0 && !status_req_reg)

endmodule
